// ===== design/slis_pkg.sv =====
package slis_pkg;

    localparam int LINE_W = 16;
    localparam int NODE_W = 16;

    localparam logic [NODE_W-1:0] NO_MATCH = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_APPEND  = 2'd1,
        OP_EXACT   = 2'd2,
        OP_GREATER = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_LAST,
        S_DONE
    } state_t;

endpackage

// ===== design/slis_ram.sv =====
module slis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== design/sorted_line_index_search.sv =====
// Sorted line index: a table of (line number, node address) pairs kept in
// append order, searched by binary search.
// Input channel s_axis: tuser carries the op (clear, append, find exact,
// find next greater), tdata carries line_no and node_addr. A beat is taken
// only while the block is idle; each beat yields exactly one result beat.
// Output channel m_axis: tdata carries the node address (0xFFFF on a miss),
// tuser carries found and full_res.
// Clear and append: the input beat moves the core to the done state, which
// loads the output register; the core is then idle for the next beat.
// Searches: each probe takes a read state and a compare state, since each
// probe waits on the registered read of the table RAM. A search makes k
// probes, k <= ceil(log2(n+1)) for n entries, then the done state loads the
// output register; a next-greater hit adds a state for one read of the
// chosen entry. A new beat is taken only once the core is back to idle.
// Reset empties the table (entry count to zero) and drops any pending
// result; RAM contents are not cleared and need no sweep.
// If the receiver stalls, the finished result waits in the output register
// and the next beat is accepted; that one then holds in the core until the
// output register frees up.
module sorted_line_index_search #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // line_no[15:0], node_addr[31:16]
    input  logic [1:0]  s_axis_tuser,   // op[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // addr[15:0]
    output logic [1:0]  m_axis_tuser    // found[0], full_res[1]
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int WW = slis_pkg::LINE_W + slis_pkg::NODE_W;

    slis_pkg::state_t state_reg, state_next;
    slis_pkg::op_t    op_reg, op_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    lo_reg, lo_next;
    logic [CW-1:0]    hi_reg, hi_next;
    logic [slis_pkg::LINE_W-1:0] key_reg, key_next;

    logic                        res_found_reg, res_found_next;
    logic [slis_pkg::NODE_W-1:0] res_addr_reg, res_addr_next;
    logic                        res_full_reg, res_full_next;

    logic                        m_valid_reg, m_valid_next;
    logic                        m_found_reg, m_found_next;
    logic [slis_pkg::NODE_W-1:0] m_addr_reg, m_addr_next;
    logic                        m_full_reg, m_full_next;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [WW-1:0] ram_wdata;
    logic [WW-1:0] ram_rdata;

    logic [CW:0]   mid_sum;
    logic [CW-1:0] mid_full;
    logic [AW-1:0] mid_idx;
    logic [CW-1:0] mid_plus1;
    logic [slis_pkg::LINE_W-1:0] probe_line;
    logic [slis_pkg::NODE_W-1:0] probe_node;
    logic s_accept;

    assign s_accept   = s_axis_tvalid && s_axis_tready;
    assign probe_line = ram_rdata[slis_pkg::LINE_W-1:0];
    assign probe_node = ram_rdata[WW-1:slis_pkg::LINE_W];

    // exact search keeps hi as one past the inclusive bound, so its
    // midpoint is (lo + hi - 1) / 2
    always_comb
    begin
        mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
        if (op_reg == slis_pkg::OP_EXACT)
        begin
            mid_sum = mid_sum - (CW+1)'(1);
        end
        mid_full  = mid_sum[CW:1];
        mid_idx   = mid_full[AW-1:0];
        mid_plus1 = mid_full + CW'(1);
    end

    slis_ram #(
        .WIDTH (WW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        count_next     = count_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        key_next       = key_reg;
        res_found_next = res_found_reg;
        res_addr_next  = res_addr_reg;
        res_full_next  = res_full_reg;
        m_valid_next   = m_valid_reg;
        m_found_next   = m_found_reg;
        m_addr_next    = m_addr_reg;
        m_full_next    = m_full_reg;
        ram_we         = 1'b0;
        ram_addr       = mid_idx;
        ram_wdata      = s_axis_tdata;

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            slis_pkg::S_IDLE:
            begin
                if (s_accept)
                begin
                    op_next        = slis_pkg::op_t'(s_axis_tuser);
                    key_next       = s_axis_tdata[slis_pkg::LINE_W-1:0];
                    res_found_next = 1'b0;
                    res_addr_next  = slis_pkg::NO_MATCH;
                    res_full_next  = 1'b0;
                    lo_next        = '0;
                    hi_next        = count_reg;
                    case (slis_pkg::op_t'(s_axis_tuser))
                        slis_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                            state_next = slis_pkg::S_DONE;
                        end
                        slis_pkg::OP_APPEND:
                        begin
                            if (count_reg < CW'(TABLE_DEPTH))
                            begin
                                ram_we         = 1'b1;
                                ram_addr       = count_reg[AW-1:0];
                                count_next     = count_reg + CW'(1);
                                res_found_next = 1'b1;
                            end
                            else
                            begin
                                res_full_next = 1'b1;
                            end
                            state_next = slis_pkg::S_DONE;
                        end
                        default:
                        begin
                            state_next = slis_pkg::S_READ;
                        end
                    endcase
                end
            end
            slis_pkg::S_READ:
            begin
                if (lo_reg < hi_reg)
                begin
                    state_next = slis_pkg::S_CMP;
                end
                else if (op_reg == slis_pkg::OP_GREATER && lo_reg < count_reg)
                begin
                    ram_addr   = lo_reg[AW-1:0];
                    state_next = slis_pkg::S_LAST;
                end
                else
                begin
                    state_next = slis_pkg::S_DONE;
                end
            end
            slis_pkg::S_CMP:
            begin
                state_next = slis_pkg::S_READ;
                if (op_reg == slis_pkg::OP_EXACT)
                begin
                    if (probe_line == key_reg)
                    begin
                        res_found_next = 1'b1;
                        res_addr_next  = probe_node;
                        state_next     = slis_pkg::S_DONE;
                    end
                    else if (probe_line < key_reg)
                    begin
                        lo_next = mid_plus1;
                    end
                    else
                    begin
                        hi_next = mid_full;
                    end
                end
                else
                begin
                    if (probe_line <= key_reg)
                    begin
                        lo_next = mid_plus1;
                    end
                    else
                    begin
                        hi_next = mid_full;
                    end
                end
            end
            slis_pkg::S_LAST:
            begin
                res_found_next = 1'b1;
                res_addr_next  = probe_node;
                state_next     = slis_pkg::S_DONE;
            end
            slis_pkg::S_DONE:
            begin
                if (!m_valid_next)
                begin
                    m_valid_next = 1'b1;
                    m_found_next = res_found_reg;
                    m_addr_next  = res_addr_reg;
                    m_full_next  = res_full_reg;
                    state_next   = slis_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = slis_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= slis_pkg::S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        key_reg       <= key_next;
        res_found_reg <= res_found_next;
        res_addr_reg  <= res_addr_next;
        res_full_reg  <= res_full_next;
        m_found_reg   <= m_found_next;
        m_addr_reg    <= m_addr_next;
        m_full_reg    <= m_full_next;
    end

    assign s_axis_tready = (state_reg == slis_pkg::S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_addr_reg;
    assign m_axis_tuser  = {m_full_reg, m_found_reg};

endmodule

// ===== design/slis_checker.sv =====
module slis_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [31:0] s_axis_tdata,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // no result beat survives reset
    a_reset_clears: assert property (@(posedge clk)
        !rst_n |-> !m_axis_tvalid)
        else $error("result beat valid during reset");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed under stall");

    // one item in flight: an accepted beat closes the input side
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while an item is in work");

    // dropped append and miss both report the no-match address
    a_miss_addr: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (!m_axis_tuser[0] || m_axis_tuser[1]) |->
            m_axis_tdata == 16'hFFFF && !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("miss or full result with bad address or flags");

endmodule

bind sorted_line_index_search slis_checker u_slis_checker (.*);
